FILE: rtl/vpa_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vpa_pkg
// Shared codes and sequencer states of the variable partition allocator.
// ---------------------------------------------------------------------------
package vpa_pkg;

   // Request word operation codes.
   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   // Placement policies held in the policy register.
   localparam logic [1:0] FIT_BEST  = 2'd0;
   localparam logic [1:0] FIT_FIRST = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;
   localparam logic [1:0] FIT_NEXT  = 2'd3;

   // Register indexes on the configuration port.
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FIT_POLICY = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_POOL_SIZE  = 2'd1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_SPLIT,
      ST_GRANT,
      ST_COMPACT,
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/vpa_entry_mem.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vpa_entry_mem
// Block table storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module vpa_entry_mem #(
   parameter int unsigned WIDTH = 57,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: rtl/vpa_fit_key.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vpa_fit_key
// Decides whether one table entry can serve a request and forms its
// ranking key under the selected policy; the smallest key wins.
// ---------------------------------------------------------------------------
module vpa_fit_key #(
   parameter int unsigned ADDR_BITS  = 16,
   parameter int unsigned OWNER_BITS = 8
) (
   input  wire logic [1:0]            policy,
   input  wire logic [ADDR_BITS:0]    req_size,
   input  wire logic [ADDR_BITS-1:0]  from_addr,
   input  wire logic [ADDR_BITS-1:0]  ent_start,
   input  wire logic [ADDR_BITS:0]    ent_size,
   input  wire logic [OWNER_BITS-1:0] ent_owner,
   output logic                       candidate,
   output logic      [ADDR_BITS:0]    key
);
   import vpa_pkg::*;

   logic fits;

   assign fits = (ent_owner == '0) && (ent_size >= req_size);

   always_comb begin
      candidate = fits;
      key       = '0;
      case (policy)
         FIT_BEST:  key = ent_size - req_size;
         FIT_FIRST: key = {1'b0, ent_start};
         FIT_WORST: key = ~ent_size;
         default: begin
            candidate = fits && (ent_start >= from_addr);
            key       = {1'b0, ent_start - from_addr};
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/variable_partition_allocator_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// variable_partition_allocator_top
// Contiguous block allocator with best, first, worst and next fit policies.
// ---------------------------------------------------------------------------
// The block table lives in a single synchronous RAM, one entry per block
// holding start, end, size and owner, and the block handles one request
// word at a time. An allocate reads every table entry in turn, one read a
// cycle, to rank the free blocks, then, if a block fits, writes the split
// remainder when there is one and then the granted block. A release makes
// the same scan to find the block and its free neighbours, then, if it
// finds the block, a second pass over the table copies every surviving
// entry down to close the gaps. After reset the block writes the initial
// free entry before it takes the first word. Writing the pool size register
// rewrites entry 0 at once and must only be done while the block is idle.
// A pool size of zero empties the table instead. A finished result sits in
// an output register, so the next request word can be accepted while the
// previous result is stalled.
// ---------------------------------------------------------------------------
module variable_partition_allocator_top #(
   parameter int unsigned MAP_ENTRIES = 32,
   parameter int unsigned ADDR_BITS   = 16,
   parameter int unsigned OWNER_BITS  = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration port
   input  wire logic                                  csr_we,
   input  wire logic [vpa_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [ADDR_BITS:0]                    csr_wdata,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_mode,
   input  wire logic [ADDR_BITS:0]                    req_request_size,
   input  wire logic [OWNER_BITS-1:0]                 req_owner_id,
   input  wire logic [ADDR_BITS-1:0]                  req_next_fit_from,
   input  wire logic [ADDR_BITS-1:0]                  req_release_start,
   input  wire logic [ADDR_BITS-1:0]                  req_release_end,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_found,
   output logic      [ADDR_BITS-1:0]                  rsp_block_start,
   output logic      [ADDR_BITS-1:0]                  rsp_block_end,
   output logic      [ADDR_BITS:0]                    rsp_block_size,
   output logic      [OWNER_BITS-1:0]                 rsp_block_owner,
   output logic      [$clog2(MAP_ENTRIES+1)-1:0]      rsp_entries_in_use
);
   import vpa_pkg::*;

   localparam int unsigned SIZE_BITS = ADDR_BITS + 1;
   localparam int unsigned IDX_W     = $clog2(MAP_ENTRIES);
   localparam int unsigned CNT_W     = $clog2(MAP_ENTRIES + 1);
   localparam int unsigned ENT_W     = 2 * ADDR_BITS + SIZE_BITS + OWNER_BITS;
   localparam logic [CNT_W-1:0]     MAP_FULL = CNT_W'(MAP_ENTRIES);
   localparam logic [SIZE_BITS-1:0] POOL_MAX = {1'b1, {ADDR_BITS{1'b0}}};
   localparam logic [SIZE_BITS-1:0] SIZE_ONE = SIZE_BITS'(1);

   // Sequencer and table count.
   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       policy_ff, policy_in;

   // Latched request word.
   logic                  mode_ff, mode_in;
   logic [SIZE_BITS-1:0]  req_ff, req_in;
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic [ADDR_BITS-1:0]  from_ff, from_in;
   logic [ADDR_BITS-1:0]  rs_ff, rs_in;
   logic [ADDR_BITS-1:0]  re_ff, re_in;

   // Table walk: read pointer, returning-data tag and compaction write pointer.
   logic [CNT_W-1:0] rd_ff, rd_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic [CNT_W-1:0] wr_ff, wr_in;

   // Chosen block (allocate) or released block (release).
   logic                  has_f_ff, has_f_in;
   logic [IDX_W-1:0]      f_idx_ff, f_idx_in;
   logic [ADDR_BITS-1:0]  f_start_ff, f_start_in;
   logic [ADDR_BITS-1:0]  f_end_ff, f_end_in;
   logic [SIZE_BITS-1:0]  f_size_ff, f_size_in;
   logic [SIZE_BITS-1:0]  key_ff, key_in;
   // Free neighbours of a released block.
   logic                  has_p_ff, has_p_in;
   logic [IDX_W-1:0]      p_idx_ff, p_idx_in;
   logic [ADDR_BITS-1:0]  p_start_ff, p_start_in;
   logic [SIZE_BITS-1:0]  p_size_ff, p_size_in;
   logic                  has_n_ff, has_n_in;
   logic [IDX_W-1:0]      n_idx_ff, n_idx_in;
   logic [ADDR_BITS-1:0]  n_end_ff, n_end_in;
   logic [SIZE_BITS-1:0]  n_size_ff, n_size_in;

   logic ok_ff, ok_in;
   logic split_ff, split_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [ADDR_BITS-1:0]  rsp_start_ff, rsp_start_in;
   logic [ADDR_BITS-1:0]  rsp_end_ff, rsp_end_in;
   logic [SIZE_BITS-1:0]  rsp_size_ff, rsp_size_in;
   logic [OWNER_BITS-1:0] rsp_owner_ff, rsp_owner_in;
   logic [CNT_W-1:0]      rsp_cnt_ff, rsp_cnt_in;

   // Memory port.
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [ENT_W-1:0] mem_wdata;
   logic [IDX_W-1:0] mem_raddr;
   logic [ENT_W-1:0] mem_rdata;

   logic [ADDR_BITS-1:0]  ent_start, ent_end;
   logic [SIZE_BITS-1:0]  ent_size;
   logic [OWNER_BITS-1:0] ent_owner;
   logic                  cand;
   logic [SIZE_BITS-1:0]  cand_key;

   logic                  req_fire, rsp_free, issue, walk_done;
   logic                  csr_pool_wr;
   logic [SIZE_BITS-1:0]  pool_sat;
   logic                  hit_f, hit_p, hit_n, drop_cur;
   logic [ADDR_BITS-1:0]  merged_start, merged_end, grant_end;
   logic [SIZE_BITS-1:0]  merged_size, grant_size;

   vpa_entry_mem #(
      .WIDTH (ENT_W),
      .DEPTH (MAP_ENTRIES)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign ent_start = mem_rdata[ENT_W-1 -: ADDR_BITS];
   assign ent_end   = mem_rdata[ENT_W-ADDR_BITS-1 -: ADDR_BITS];
   assign ent_size  = mem_rdata[OWNER_BITS +: SIZE_BITS];
   assign ent_owner = mem_rdata[OWNER_BITS-1:0];

   vpa_fit_key #(
      .ADDR_BITS  (ADDR_BITS),
      .OWNER_BITS (OWNER_BITS)
   ) u_fit (
      .policy    (policy_ff),
      .req_size  (req_ff),
      .from_addr (from_ff),
      .ent_start (ent_start),
      .ent_size  (ent_size),
      .ent_owner (ent_owner),
      .candidate (cand),
      .key       (cand_key)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // The walk issues one read a cycle until the count is reached; its data
   // returns in the following cycle, tagged with the entry index.
   assign issue     = (rd_ff < cnt_ff);
   assign walk_done = !issue && !pend_ff;
   assign mem_raddr = rd_ff[IDX_W-1:0];

   // Role matching while scanning for a release; the first role that
   // matches an entry takes it.
   assign hit_f = (ent_start == rs_ff);
   assign hit_p = !hit_f && (ent_owner == '0)
                  && (({1'b0, ent_end} + SIZE_ONE) == {1'b0, rs_ff});
   assign hit_n = !hit_f && !hit_p && (ent_owner == '0)
                  && ({1'b0, ent_start} == ({1'b0, re_ff} + SIZE_ONE));

   assign drop_cur = (has_p_ff && (pidx_ff == p_idx_ff))
                     || (has_n_ff && (pidx_ff == n_idx_ff));

   // Merged free block after a release; sizes wrap to their width.
   assign merged_start = has_p_ff ? p_start_ff : f_start_ff;
   assign merged_end   = has_n_ff ? n_end_ff : f_end_ff;
   assign merged_size  = f_size_ff + (has_p_ff ? p_size_ff : '0)
                         + (has_n_ff ? n_size_ff : '0);

   // Granted block after an allocate.
   assign grant_end  = split_ff ? (f_start_ff + req_ff[ADDR_BITS-1:0]
                                   - ADDR_BITS'(1)) : f_end_ff;
   assign grant_size = split_ff ? req_ff : f_size_ff;

   assign csr_pool_wr = csr_we && (csr_index == REG_POOL_SIZE);
   assign pool_sat    = (csr_wdata > POOL_MAX) ? POOL_MAX : csr_wdata;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (walk_done) begin
               if (mode_ff == MODE_ALLOC) begin
                  if (!ok_in) begin
                     state_in = ST_RESP;
                  end else if (split_in) begin
                     state_in = ST_SPLIT;
                  end else begin
                     state_in = ST_GRANT;
                  end
               end else if (has_f_ff) begin
                  state_in = ST_COMPACT;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SPLIT:   state_in = ST_GRANT;
         ST_GRANT:   state_in = ST_RESP;
         ST_COMPACT: begin
            if (walk_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      cnt_in     = cnt_ff;
      policy_in  = policy_ff;
      mode_in    = mode_ff;
      req_in     = req_ff;
      owner_in   = owner_ff;
      from_in    = from_ff;
      rs_in      = rs_ff;
      re_in      = re_ff;
      rd_in      = rd_ff;
      pend_in    = 1'b0;
      pidx_in    = rd_ff[IDX_W-1:0];
      wr_in      = wr_ff;
      has_f_in   = has_f_ff;
      f_idx_in   = f_idx_ff;
      f_start_in = f_start_ff;
      f_end_in   = f_end_ff;
      f_size_in  = f_size_ff;
      key_in     = key_ff;
      has_p_in   = has_p_ff;
      p_idx_in   = p_idx_ff;
      p_start_in = p_start_ff;
      p_size_in  = p_size_ff;
      has_n_in   = has_n_ff;
      n_idx_in   = n_idx_ff;
      n_end_in   = n_end_ff;
      n_size_in  = n_size_ff;
      ok_in      = ok_ff;
      split_in   = split_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_owner_in = rsp_owner_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wdata  = '0;

      unique case (state_ff)
         ST_INIT: begin
            // Reset contents: one free block covering the whole pool.
            mem_we    = 1'b1;
            mem_wdata = {{ADDR_BITS{1'b0}}, {ADDR_BITS{1'b1}}, POOL_MAX,
                         {OWNER_BITS{1'b0}}};
         end
         ST_IDLE: begin
            mode_in  = req_mode;
            req_in   = req_request_size;
            owner_in = req_owner_id;
            from_in  = req_next_fit_from;
            rs_in    = req_release_start;
            re_in    = req_release_end;
            rd_in    = '0;
            has_f_in = 1'b0;
            has_p_in = 1'b0;
            has_n_in = 1'b0;
         end
         ST_SCAN: begin
            pend_in = issue;
            rd_in   = rd_ff + CNT_W'(issue);
            if (pend_ff) begin
               if (mode_ff == MODE_ALLOC) begin
                  if (cand && (!has_f_ff || (cand_key < key_ff))) begin
                     has_f_in   = 1'b1;
                     f_idx_in   = pidx_ff;
                     f_start_in = ent_start;
                     f_end_in   = ent_end;
                     f_size_in  = ent_size;
                     key_in     = cand_key;
                  end
               end else if (hit_f) begin
                  has_f_in   = 1'b1;
                  f_idx_in   = pidx_ff;
                  f_start_in = ent_start;
                  f_end_in   = ent_end;
                  f_size_in  = ent_size;
               end else if (hit_p) begin
                  has_p_in   = 1'b1;
                  p_idx_in   = pidx_ff;
                  p_start_in = ent_start;
                  p_size_in  = ent_size;
               end else if (hit_n) begin
                  has_n_in   = 1'b1;
                  n_idx_in   = pidx_ff;
                  n_end_in   = ent_end;
                  n_size_in  = ent_size;
               end
            end
            // Decision, used on the cycle the walk finishes.
            split_in = (f_size_ff > req_ff);
            if (mode_ff == MODE_ALLOC) begin
               ok_in = (req_ff != '0) && (owner_ff != '0) && has_f_ff
                       && !(split_in && (cnt_ff >= MAP_FULL));
            end else begin
               ok_in = has_f_ff;
            end
            rd_in = walk_done ? '0 : rd_in;
            wr_in = '0;
         end
         ST_SPLIT: begin
            // Remainder goes to a new free entry at the end of the table.
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[IDX_W-1:0];
            mem_wdata = {f_start_ff + req_ff[ADDR_BITS-1:0], f_end_ff,
                         f_size_ff - req_ff, {OWNER_BITS{1'b0}}};
            cnt_in    = cnt_ff + CNT_W'(1);
         end
         ST_GRANT: begin
            mem_we    = 1'b1;
            mem_waddr = f_idx_ff;
            mem_wdata = {f_start_ff, grant_end, grant_size, owner_ff};
         end
         ST_COMPACT: begin
            // Copy survivors down; writes never pass the read pointer.
            pend_in = issue;
            rd_in   = rd_ff + CNT_W'(issue);
            if (pend_ff && !drop_cur) begin
               mem_we    = 1'b1;
               mem_waddr = wr_ff[IDX_W-1:0];
               mem_wdata = (pidx_ff == f_idx_ff)
                           ? {merged_start, merged_end, merged_size,
                              {OWNER_BITS{1'b0}}}
                           : mem_rdata;
               wr_in     = wr_ff + CNT_W'(1);
            end
            if (walk_done) begin
               cnt_in = wr_ff;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = ok_ff;
               // The count is captured with the word, as the next request
               // may change the table while this word is still stalled.
               rsp_cnt_in   = cnt_ff;
               if (!ok_ff) begin
                  rsp_start_in = '0;
                  rsp_end_in   = '0;
                  rsp_size_in  = '0;
                  rsp_owner_in = '0;
               end else if (mode_ff == MODE_ALLOC) begin
                  rsp_start_in = f_start_ff;
                  rsp_end_in   = grant_end;
                  rsp_size_in  = grant_size;
                  rsp_owner_in = owner_ff;
               end else begin
                  rsp_start_in = merged_start;
                  rsp_end_in   = merged_end;
                  rsp_size_in  = merged_size;
                  rsp_owner_in = '0;
               end
            end
         end
         default: begin
         end
      endcase

      // Configuration writes take priority; user must send them only while idle.
      if (csr_we && (csr_index == REG_FIT_POLICY)) begin
         policy_in = csr_wdata[1:0];
      end
      if (csr_pool_wr) begin
         if (pool_sat == '0) begin
            cnt_in = '0;
         end else begin
            cnt_in    = CNT_W'(1);
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = {{ADDR_BITS{1'b0}}, pool_sat[ADDR_BITS-1:0] - ADDR_BITS'(1),
                         pool_sat, {OWNER_BITS{1'b0}}};
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= CNT_W'(1);
         policy_ff    <= FIT_BEST;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         policy_ff    <= policy_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      req_ff       <= req_in;
      owner_ff     <= owner_in;
      from_ff      <= from_in;
      rs_ff        <= rs_in;
      re_ff        <= re_in;
      rd_ff        <= rd_in;
      pidx_ff      <= pidx_in;
      wr_ff        <= wr_in;
      has_f_ff     <= has_f_in;
      f_idx_ff     <= f_idx_in;
      f_start_ff   <= f_start_in;
      f_end_ff     <= f_end_in;
      f_size_ff    <= f_size_in;
      key_ff       <= key_in;
      has_p_ff     <= has_p_in;
      p_idx_ff     <= p_idx_in;
      p_start_ff   <= p_start_in;
      p_size_ff    <= p_size_in;
      has_n_ff     <= has_n_in;
      n_idx_ff     <= n_idx_in;
      n_end_ff     <= n_end_in;
      n_size_ff    <= n_size_in;
      ok_ff        <= ok_in;
      split_ff     <= split_in;
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_owner_ff <= rsp_owner_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_block_start    = rsp_start_ff;
   assign rsp_block_end      = rsp_end_ff;
   assign rsp_block_size     = rsp_size_ff;
   assign rsp_block_owner    = rsp_owner_ff;
   assign rsp_entries_in_use = rsp_cnt_ff;

`ifndef SYNTHESIS
   // The table never holds more blocks than it has entries.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAP_FULL)
      else $error("block count exceeds table depth");

   // A miss carries an all-zero block description.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |->
      (rsp_size_ff == '0 && rsp_owner_ff == '0 && rsp_start_ff == '0))
      else $error("miss response carries block data");

   // An accepted word always starts a table scan on the next cycle.
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SCAN))
      else $error("accepted word did not start a scan");
`endif

endmodule
`default_nettype wire
